@@ hdl/plcs_pkg.sv @@
// Shared constants and register codes for the piecewise-linear contrast stretch.
package plcs_pkg;

  localparam int unsigned CFG_IDX_BITS = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KNEE_IN_LOW   = 8'd0,
    REG_KNEE_OUT_LOW  = 8'd1,
    REG_KNEE_IN_HIGH  = 8'd2,
    REG_KNEE_OUT_HIGH = 8'd3
  } cfg_reg_e;

  localparam int unsigned KNEE_IN_LOW_RST   = 64;
  localparam int unsigned KNEE_OUT_LOW_RST  = 32;
  localparam int unsigned KNEE_IN_HIGH_RST  = 192;
  localparam int unsigned KNEE_OUT_HIGH_RST = 224;

endpackage

@@ hdl/plcs_if.sv @@
// Stream and configuration channel interfaces for the contrast stretch block.
interface plcs_in_if #(parameter int unsigned PIXEL_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface plcs_out_if #(parameter int unsigned PIXEL_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

interface plcs_cfg_if
  import plcs_pkg::*;
#(parameter int unsigned PIXEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [PIXEL_BITS-1:0]   reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

@@ hdl/plcs_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, W stages, elastic.
module plcs_div #(
  parameter int unsigned W      = 8,
  parameter int unsigned SIDE_W = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  output logic              rdy_o,
  input  logic [2*W-1:0]    num_i,   // num_i < den_i * 2^W
  input  logic [W-1:0]      den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  input  logic              rdy_i,
  output logic [W-1:0]      quo_o,
  output logic              rem_nz_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_q    [W];
  logic [W-1:0]      rem_q  [W];
  logic [W-1:0]      low_q  [W];
  logic [W-1:0]      quo_q  [W];
  logic [W-1:0]      den_q  [W];
  logic [SIDE_W-1:0] side_q [W];
  logic [W:0]        en;

  assign en[W] = rdy_i;

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic              in_v;
    logic [W-1:0]      in_rem;
    logic [W-1:0]      in_low;
    logic [W-1:0]      in_quo;
    logic [W-1:0]      in_den;
    logic [SIDE_W-1:0] in_side;
    logic [W:0]        trial;
    logic [W:0]        diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign in_v    = vld_i;
      assign in_rem  = num_i[2*W-1:W];
      assign in_low  = num_i[W-1:0];
      assign in_quo  = '0;
      assign in_den  = den_i;
      assign in_side = side_i;
    end else begin : g_next
      assign in_v    = v_q[j-1];
      assign in_rem  = rem_q[j-1];
      assign in_low  = low_q[j-1];
      assign in_quo  = quo_q[j-1];
      assign in_den  = den_q[j-1];
      assign in_side = side_q[j-1];
    end

    // partial remainder stays below den, so the trial fits in W+1 bits
    assign trial = {in_rem, in_low[W-1]};
    assign diff  = trial - {1'b0, in_den};
    assign ge    = trial >= {1'b0, in_den};
    assign en[j] = ~v_q[j] | en[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        rem_q[j]  <= ge ? diff[W-1:0] : trial[W-1:0];
        low_q[j]  <= {in_low[W-2:0], 1'b0};
        quo_q[j]  <= {in_quo[W-2:0], ge};
        den_q[j]  <= in_den;
        side_q[j] <= in_side;
      end
    end
  end

  assign rdy_o    = en[0];
  assign vld_o    = v_q[W-1];
  assign quo_o    = quo_q[W-1];
  assign rem_nz_o = |rem_q[W-1];
  assign side_o   = side_q[W-1];

endmodule

@@ hdl/piecewise_linear_contrast_stretch_top.sv @@
// Pipeline: segment select, multiply, one divider stage per quotient bit, and the
// output register. Throughput: one pixel per clock while the output is not stalled;
// every stage is elastic, a stall fills bubbles. Reset: valid bits clear, knees load
// 64/32/192/224. Config ready is always high; the user must write knees only while no
// pixel is in flight; the block itself does not enforce this.
module piecewise_linear_contrast_stretch_top
  import plcs_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  plcs_in_if.sink    pix_i,
  plcs_out_if.source pix_o,
  plcs_cfg_if.sink   cfg_i
);

  localparam int unsigned W      = PIXEL_BITS;
  localparam int unsigned SIDE_W = W + 1;

  // knee registers
  logic [W-1:0] kil_q, kol_q, kih_q, koh_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kil_q <= W'(KNEE_IN_LOW_RST);
      kol_q <= W'(KNEE_OUT_LOW_RST);
      kih_q <= W'(KNEE_IN_HIGH_RST);
      koh_q <= W'(KNEE_OUT_HIGH_RST);
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_KNEE_IN_LOW:   kil_q <= cfg_i.reg_data;
        REG_KNEE_OUT_LOW:  kol_q <= cfg_i.reg_data;
        REG_KNEE_IN_HIGH:  kih_q <= cfg_i.reg_data;
        REG_KNEE_OUT_HIGH: koh_q <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  // stage A: segment select
  logic [W-1:0] r_lo, s_lo, r_hi, s_hi, den_d, off_d, dmag_d;
  logic         neg_d;
  logic         a_v_q;
  logic [W-1:0] a_off_q, a_dmag_q, a_den_q, a_slo_q;
  logic         a_neg_q;
  logic         en_a, en_b, en_out, div_rdy;

  always_comb begin
    if (pix_i.pixel_in <= kil_q) begin
      r_lo = '0;
      s_lo = '0;
      r_hi = kil_q;
      s_hi = kol_q;
    end else if (pix_i.pixel_in <= kih_q) begin
      r_lo = kil_q;
      s_lo = kol_q;
      r_hi = kih_q;
      s_hi = koh_q;
    end else begin
      r_lo = kih_q;
      s_lo = koh_q;
      r_hi = '1;
      s_hi = '1;
    end
    den_d = r_hi - r_lo;
    off_d = pix_i.pixel_in - r_lo;
    // empty segment answers its upper knee level
    if (den_d == '0) begin
      s_lo  = s_hi;
      den_d = W'(1);
      off_d = '0;
    end
    neg_d  = s_hi < s_lo;
    dmag_d = neg_d ? (s_lo - s_hi) : (s_hi - s_lo);
  end

  assign en_a        = ~a_v_q | en_b;
  assign pix_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_a) begin
      a_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_off_q  <= off_d;
      a_dmag_q <= dmag_d;
      a_den_q  <= den_d;
      a_slo_q  <= s_lo;
      a_neg_q  <= neg_d;
    end
  end

  // stage B: |slope numerator| * offset
  logic              b_v_q;
  logic [2*W-1:0]    b_num_q;
  logic [W-1:0]      b_den_q;
  logic [SIDE_W-1:0] b_side_q;

  assign en_b = ~b_v_q | div_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_b) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b_num_q  <= (2*W)'(a_dmag_q) * (2*W)'(a_off_q);
      b_den_q  <= a_den_q;
      b_side_q <= {a_neg_q, a_slo_q};
    end
  end

  // divider
  logic              d_v;
  logic [W-1:0]      d_quo;
  logic              d_nz;
  logic [SIDE_W-1:0] d_side;
  logic              d_neg;
  logic [W-1:0]      d_slo;

  plcs_div #(
    .W      (W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (b_v_q),
    .rdy_o    (div_rdy),
    .num_i    (b_num_q),
    .den_i    (b_den_q),
    .side_i   (b_side_q),
    .vld_o    (d_v),
    .rdy_i    (en_out),
    .quo_o    (d_quo),
    .rem_nz_o (d_nz),
    .side_o   (d_side)
  );

  assign d_neg = d_side[W];
  assign d_slo = d_side[W-1:0];

  // output stage: falling segment floors toward minus infinity
  logic         o_v_q;
  logic [W-1:0] o_pix_q;
  logic [W-1:0] res_d;

  assign res_d  = d_neg ? (d_slo - d_quo - W'(d_nz)) : (d_slo + d_quo);
  assign en_out = ~o_v_q | pix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en_out) begin
      o_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      o_pix_q <= res_d;
    end
  end

  assign pix_o.valid     = o_v_q;
  assign pix_o.pixel_out = o_pix_q;

  // checks
  logic [W:0] rise_sum;
  logic [W:0] fall_sub;

  assign rise_sum = {1'b0, d_slo} + {1'b0, d_quo};
  assign fall_sub = {1'b0, d_slo} - {1'b0, d_quo} - (W+1)'(d_nz);

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v_q |-> (b_num_q[2*W-1:W] < b_den_q))
    else $error("numerator exceeds divider quotient range");

  a_rise_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v && !d_neg) |-> !rise_sum[W])
    else $error("rising segment result overflows");

  a_fall_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v && d_neg) |-> !fall_sub[W])
    else $error("falling segment result underflows");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (pix_o.valid && !pix_o.ready))
    else $error("input stalled without a stalled output");

endmodule

@@ dv/piecewise_linear_contrast_stretch_top_tb.sv @@
// Self-checking testbench for the piecewise-linear contrast stretch top level.
module piecewise_linear_contrast_stretch_top_tb
  import plcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIX_W       = 8;
  localparam int          PIX_MAX     = (1 << PIX_W) - 1;
  localparam int          LATENCY     = PIX_W + 3;
  localparam int          HOLD_CYCLES = 200;
  localparam int          RAND_PHASES = 12;
  localparam int          PHASE_ITEMS = 120;
  localparam int          MAX_REPORTS = 10;

  // indexes past the last knee register; writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_FIRST =
    CFG_IDX_BITS'(REG_KNEE_OUT_HIGH + 1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LAST  = '1;

  typedef logic [PIX_W-1:0] level_t;

  class stretch_scoreboard;
    level_t      knee_in_lo;
    level_t      knee_out_lo;
    level_t      knee_in_hi;
    level_t      knee_out_hi;
    level_t      stretched_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      knee_in_lo  = level_t'(KNEE_IN_LOW_RST);
      knee_out_lo = level_t'(KNEE_OUT_LOW_RST);
      knee_in_hi  = level_t'(KNEE_IN_HIGH_RST);
      knee_out_hi = level_t'(KNEE_OUT_HIGH_RST);
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void write_knee(logic [CFG_IDX_BITS-1:0] idx, level_t val);
      case (idx)
        REG_KNEE_IN_LOW:   knee_in_lo  = val;
        REG_KNEE_OUT_LOW:  knee_out_lo = val;
        REG_KNEE_IN_HIGH:  knee_in_hi  = val;
        REG_KNEE_OUT_HIGH: knee_out_hi = val;
        default: ;
      endcase
    endfunction

    // floor of the line value; negative slopes round toward minus infinity
    function level_t segment_level(int r_lo, int s_lo, int r_hi, int s_hi, int p);
      int den;
      int num;
      int q;
      den = r_hi - r_lo;
      if (den <= 0) return level_t'(s_hi);
      num = (s_hi - s_lo) * (p - r_lo);
      if (num >= 0) q = num / den;
      else q = -((-num + den - 1) / den);
      return level_t'(s_lo + q);
    endfunction

    function level_t stretch(level_t p);
      if (p <= knee_in_lo)
        return segment_level(0, 0, knee_in_lo, knee_out_lo, p);
      else if (p <= knee_in_hi)
        return segment_level(knee_in_lo, knee_out_lo, knee_in_hi, knee_out_hi, p);
      else
        return segment_level(knee_in_hi, knee_out_hi, PIX_MAX, PIX_MAX, p);
    endfunction

    function void note_pixel(level_t p);
      stretched_q = {stretched_q, stretch(p)};
    endfunction

    function void check_result(level_t actual);
      level_t want;
      checked++;
      if (stretched_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected pixel_out %0d, nothing pending", $realtime, actual);
        return;
      end
      want = stretched_q.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] pixel_out mismatch: expected %0d, got %0d",
                   $realtime, want, actual);
      end
    endfunction
  endclass

  logic clk;
  logic rst_ni;

  plcs_in_if  #(.PIXEL_BITS(PIX_W)) pix_in_if ();
  plcs_out_if #(.PIXEL_BITS(PIX_W)) pix_out_if ();
  plcs_cfg_if #(.PIXEL_BITS(PIX_W)) cfg_if ();

  piecewise_linear_contrast_stretch_top #(.PIXEL_BITS(PIX_W)) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .pix_i  (pix_in_if),
    .pix_o  (pix_out_if),
    .cfg_i  (cfg_if)
  );

  stretch_scoreboard sb = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_req;
  int unsigned pixels_sent;
  int unsigned settings_used;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure plus long hold-offs on request
  initial begin
    int stall_seen;
    int hold_left;
    stall_seen = 0;
    hold_left  = 0;
    pix_out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_if.ready <= 1'b0;
      end else begin
        pix_out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && pix_out_if.valid && pix_out_if.ready)
      sb.check_result(pix_out_if.pixel_out);
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, level_t val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.reg_data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_knee(idx, val);
  endtask

  // all four knees, then a write to an unused index that must change nothing
  task automatic set_knees(level_t r1, level_t s1, level_t r2, level_t s2);
    write_reg(REG_KNEE_IN_LOW, r1);
    write_reg(REG_KNEE_OUT_LOW, s1);
    write_reg(REG_KNEE_IN_HIGH, r2);
    write_reg(REG_KNEE_OUT_HIGH, s2);
    if ($urandom_range(1))
      write_reg(CFG_IDX_SPARE_LAST, level_t'($urandom));
    else
      write_reg(CFG_IDX_SPARE_FIRST + CFG_IDX_BITS'($urandom_range(
                CFG_IDX_SPARE_LAST - CFG_IDX_SPARE_FIRST)), level_t'($urandom));
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(level_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in_if.valid    <= 1'b1;
    pix_in_if.pixel_in <= p;
    do @(posedge clk); while (!pix_in_if.ready);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // stop offering and wait out everything in flight
  task automatic drain();
    pix_in_if.valid <= 1'b0;
    while (sb.stretched_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic level_t pick_knee();
    case ($urandom_range(7))
      0:       return '0;
      1:       return level_t'(PIX_MAX);
      default: return level_t'($urandom);
    endcase
  endfunction

  // mostly uniform, some right around a knee where segments meet
  function automatic level_t pick_pixel();
    int k;
    if ($urandom_range(9) < 7) return level_t'($urandom);
    k = $urandom_range(1) ? int'(sb.knee_in_lo) : int'(sb.knee_in_hi);
    k = k + int'($urandom_range(2)) - 1;
    if (k < 0) k = 0;
    if (k > PIX_MAX) k = PIX_MAX;
    return level_t'(k);
  endfunction

  initial begin
    pix_in_if.valid    = 1'b0;
    pix_in_if.pixel_in = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.reg_index   = '0;
    cfg_if.reg_data    = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    stall_req          = 0;
    pixels_sent        = 0;
    settings_used      = 1;
    rst_ni             = 1'b0;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // knees as left by reset
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd64);
    send_pixel(8'd65);
    send_pixel(8'd192);
    send_pixel(8'd193);
    send_pixel(8'd255);
    drain();

    // first segment of zero width, top segment of zero width
    set_knees(8'd0, 8'd100, 8'd255, 8'd200);
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd128);
    send_pixel(8'd255);
    drain();

    // knees out of order: middle segment empty
    set_knees(8'd200, 8'd50, 8'd100, 8'd150);
    send_pixel(8'd100);
    send_pixel(8'd200);
    send_pixel(8'd201);
    send_pixel(8'd255);
    drain();

    // falling middle segment
    set_knees(8'd100, 8'd200, 8'd150, 8'd20);
    send_pixel(8'd99);
    send_pixel(8'd100);
    send_pixel(8'd125);
    send_pixel(8'd151);
    drain();

    set_knees(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd255);
    drain();

    set_knees(8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd0);
    send_pixel(8'd254);
    send_pixel(8'd255);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph / 4)
        0: begin
          send_idle_pct <= 13;
          recv_idle_pct <= 85;
        end
        1: begin
          send_idle_pct <= 85;
          recv_idle_pct <= 13;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      if (ph == 1)
        set_knees(level_t'(KNEE_IN_LOW_RST), level_t'(KNEE_OUT_LOW_RST),
                  level_t'(KNEE_IN_HIGH_RST), level_t'(KNEE_OUT_HIGH_RST));
      else
        set_knees(pick_knee(), pick_knee(), pick_knee(), pick_knee());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long output hold-off while input keeps coming, so the pipe backs up
        if (n == 10 && (ph == 3 || ph == 9))
          stall_req <= stall_req + 1;
        send_pixel(pick_pixel());
      end
      drain();
    end

    $display("%0d pixels stretched and checked under %0d knee settings", pixels_sent,
             settings_used);
    $display("covered: flat, falling, out-of-order and zero-width segments, long stalls");
    if (sb.mismatches == 0 && sb.stretched_q.size() == 0) begin
      $display("piecewise_linear_contrast_stretch_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches,
               sb.stretched_q.size());
      $display("piecewise_linear_contrast_stretch_top verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", sb.stretched_q.size());
    $display("piecewise_linear_contrast_stretch_top verification failed");
    $finish;
  end

endmodule
